// ===== design/uvsg_pkg.sv =====
// Shared types, constants and arithmetic helpers for the UV sphere vertex generator.
`default_nettype none

package uvsg_pkg;

  localparam int ROTATION_STAGES = 16;
  localparam int DIV_STAGES      = 32;

  localparam int REG_INDEX_W = 2;
  localparam logic [REG_INDEX_W-1:0] REG_RADIUS       = 2'd0;
  localparam logic [REG_INDEX_W-1:0] REG_SECTOR_COUNT = 2'd1;
  localparam logic [REG_INDEX_W-1:0] REG_STACK_COUNT  = 2'd2;

  localparam logic [15:0] RADIUS_RESET       = 16'd256;
  localparam logic [10:0] SECTOR_COUNT_RESET = 11'd36;
  localparam logic [10:0] STACK_COUNT_RESET  = 11'd18;

  localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
  localparam logic signed [16:0] POS_LIMIT  = 17'sd65535;
  localparam logic signed [15:0] NORM_LIMIT = 16'sd16384;

  typedef struct packed {
    logic valid;
    logic oor;
  } tag_t;

  // One transaction in flight through the phase divider.
  typedef struct packed {
    tag_t        tag;
    logic [11:0] ru;
    logic [11:0] rv;
    logic [31:0] qu;
    logic [31:0] qv;
  } div_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [31:0]        z;
    logic               flip;
  } cordic_lane_t;

  typedef struct packed {
    tag_t         tag;
    cordic_lane_t u;
    cordic_lane_t v;
  } cordic_t;

  // Arctangent of 2^-k in phase units, one full turn being 2^32.
  function automatic logic [31:0] atan_turns(input logic [4:0] k);
    logic [31:0] a;
    case (k)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  // One micro-rotation toward zero residual phase.
  function automatic cordic_lane_t cordic_step(input cordic_lane_t a, input logic [4:0] k);
    cordic_lane_t       r;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    dx = $signed(a.y) >>> k;
    dy = $signed(a.x) >>> k;
    r = a;
    if (a.z[31]) begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + atan_turns(k);
    end else begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - atan_turns(k);
    end
    return r;
  endfunction

  // Round Q2.30 to Q2.14 and saturate.
  function automatic logic signed [15:0] to_norm(input logic signed [31:0] q);
    logic signed [31:0] t;
    logic signed [15:0] s;
    t = q + 32'sd32768;
    s = $signed(t[31:16]);
    if (s > NORM_LIMIT) begin
      s = NORM_LIMIT;
    end else if (s < -NORM_LIMIT) begin
      s = -NORM_LIMIT;
    end
    return s;
  endfunction

  // Round radius times Q2.30 down to Q8.8 and saturate.
  function automatic logic signed [16:0] to_pos(input logic signed [48:0] p);
    logic signed [48:0] t;
    logic signed [18:0] s;
    logic signed [16:0] r;
    t = p + 49'sd536870912;
    s = $signed(t[48:30]);
    if (s > 19'sd65535) begin
      r = POS_LIMIT;
    end else if (s < -19'sd65535) begin
      r = -POS_LIMIT;
    end else begin
      r = s[16:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/uvsg_div_cell.sv =====
// One restoring-division cell: retires one quotient bit per lane per cycle while en is high.
`default_nettype none

module uvsg_div_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic [4:0]    idx,
  input  wire logic [11:0]   du,
  input  wire logic [11:0]   dv,
  input  wire logic [31:0]   nu,
  input  wire logic [31:0]   nv,
  input  wire uvsg_pkg::div_t d_in,
  output uvsg_pkg::div_t     d_out
);

  uvsg_pkg::div_t d_q;
  uvsg_pkg::div_t d_next;
  logic [4:0]  bit_pos;
  logic [12:0] tu;
  logic [12:0] tv;

  assign bit_pos = ~idx;

  always_comb begin
    d_next = d_in;
    tu = {d_in.ru, nu[bit_pos]};
    tv = {d_in.rv, nv[bit_pos]};
    if (tu >= {1'b0, du}) begin
      d_next.ru = 12'(tu - {1'b0, du});
      d_next.qu = {d_in.qu[30:0], 1'b1};
    end else begin
      d_next.ru = tu[11:0];
      d_next.qu = {d_in.qu[30:0], 1'b0};
    end
    if (tv >= {1'b0, dv}) begin
      d_next.rv = 12'(tv - {1'b0, dv});
      d_next.qv = {d_in.qv[30:0], 1'b1};
    end else begin
      d_next.rv = tv[11:0];
      d_next.qv = {d_in.qv[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_q.tag.valid <= 1'b0;
    end else if (en) begin
      d_q <= d_next;
    end
  end

  assign d_out = d_q;

endmodule

`default_nettype wire

// ===== design/uvsg_cordic_cell.sv =====
// One CORDIC rotation cell working on the stack and sector lanes together.
`default_nettype none

module uvsg_cordic_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic [4:0]        idx,
  input  wire uvsg_pkg::cordic_t d_in,
  output uvsg_pkg::cordic_t      d_out
);

  uvsg_pkg::cordic_t d_q;
  uvsg_pkg::cordic_t d_next;

  always_comb begin
    d_next     = d_in;
    d_next.u   = uvsg_pkg::cordic_step(d_in.u, idx);
    d_next.v   = uvsg_pkg::cordic_step(d_in.v, idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_q.tag.valid <= 1'b0;
    end else if (en) begin
      d_q <= d_next;
    end
  end

  assign d_out = d_q;

endmodule

`default_nettype wire

// ===== design/uv_sphere_vertex_generator.sv =====
// Top level of the UV sphere vertex generator: divider chain, CORDIC chain and output math.
// The block takes one (stack_index, sector_index) transaction per cycle while in_ready
// is high and returns one vertex per transaction, in order. Along the pipeline, 32
// division cells turn each index into a 32-bit phase, one quotient bit per cell, 16
// CORDIC cells produce sine and cosine of both angles, and four output stages form
// the products, round, saturate and hold the result. The whole pipeline advances
// together whenever the output register is empty or being taken, so ready follows
// out_ready combinationally and the block sustains one vertex per cycle while out_ready
// stays high. An index above its count, or a count of zero, gives out_of_range = 1
// with all other fields zero. Write the registers (0 radius, 1 sector_count,
// 2 stack_count) only while no transaction is in flight.
`default_nettype none

module uv_sphere_vertex_generator (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [uvsg_pkg::REG_INDEX_W-1:0] cfg_index,
  input  wire logic [15:0]                      cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [10:0]                      stack_index,
  input  wire logic [10:0]                      sector_index,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [16:0]                    pos_x,
  output logic signed [16:0]                    pos_y,
  output logic signed [16:0]                    pos_z,
  output logic signed [15:0]                    normal_x,
  output logic signed [15:0]                    normal_y,
  output logic signed [15:0]                    normal_z,
  output logic                                  out_of_range
);

  // Configuration registers.
  logic [15:0] radius;
  logic [10:0] sector_count;
  logic [10:0] stack_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= uvsg_pkg::RADIUS_RESET;
      sector_count <= uvsg_pkg::SECTOR_COUNT_RESET;
      stack_count  <= uvsg_pkg::STACK_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        uvsg_pkg::REG_RADIUS:       radius       <= cfg_data;
        uvsg_pkg::REG_SECTOR_COUNT: sector_count <= cfg_data[10:0];
        uvsg_pkg::REG_STACK_COUNT:  stack_count  <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Global advance: move everything when the output register can take a result.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Divider operands. The stack phase divides 2*(i*2^31 + S/2) by 2*S, which
  // gives the same quotient with the index sitting above the 32 fraction bits.
  logic [11:0] du;
  logic [11:0] dv;
  logic [31:0] nu;
  logic [31:0] nv;

  assign du = {stack_count, 1'b0};
  assign dv = {1'b0, sector_count};
  assign nu = {21'd0, stack_count[10:1], 1'b0};
  assign nv = {22'd0, sector_count[10:1]};

  uvsg_pkg::div_t div_chain [0:uvsg_pkg::DIV_STAGES];

  always_comb begin
    div_chain[0].tag.valid = in_valid;
    div_chain[0].tag.oor   = (stack_count == 11'd0) || (sector_count == 11'd0) ||
                             (stack_index > stack_count) || (sector_index > sector_count);
    div_chain[0].ru        = {1'b0, stack_index};
    // An index equal to its count is a full turn; drop it to remainder zero.
    div_chain[0].rv        = (sector_index == sector_count) ? 12'd0 : {1'b0, sector_index};
    div_chain[0].qu        = 32'd0;
    div_chain[0].qv        = 32'd0;
  end

  for (genvar g = 0; g < uvsg_pkg::DIV_STAGES; g++) begin : g_div
    uvsg_div_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .idx   (5'(g)),
      .du    (du),
      .dv    (dv),
      .nu    (nu),
      .nv    (nv),
      .d_in  (div_chain[g]),
      .d_out (div_chain[g+1])
    );
  end

  // Phases, then fold the left half-plane by half a turn before rotating.
  uvsg_pkg::cordic_t cordic_chain [0:uvsg_pkg::ROTATION_STAGES];
  logic [31:0] uph;
  logic [31:0] vph;
  logic [31:0] uph_sum;
  logic [31:0] vph_sum;

  assign uph     = 32'h40000000 - div_chain[uvsg_pkg::DIV_STAGES].qu;
  assign vph     = div_chain[uvsg_pkg::DIV_STAGES].qv;
  assign uph_sum = uph + 32'h40000000;
  assign vph_sum = vph + 32'h40000000;

  always_comb begin
    cordic_chain[0].tag    = div_chain[uvsg_pkg::DIV_STAGES].tag;
    cordic_chain[0].u.flip = uph_sum[31];
    cordic_chain[0].u.z    = uph_sum[31] ? (uph + 32'h80000000) : uph;
    cordic_chain[0].u.x    = uvsg_pkg::GAIN_Q30;
    cordic_chain[0].u.y    = 32'sd0;
    cordic_chain[0].v.flip = vph_sum[31];
    cordic_chain[0].v.z    = vph_sum[31] ? (vph + 32'h80000000) : vph;
    cordic_chain[0].v.x    = uvsg_pkg::GAIN_Q30;
    cordic_chain[0].v.y    = 32'sd0;
  end

  for (genvar g = 0; g < uvsg_pkg::ROTATION_STAGES; g++) begin : g_cordic
    uvsg_cordic_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .idx   (5'(g)),
      .d_in  (cordic_chain[g]),
      .d_out (cordic_chain[g+1])
    );
  end

  // Undo the fold.
  uvsg_pkg::cordic_t  cor_last;
  logic signed [31:0] cu;
  logic signed [31:0] su;
  logic signed [31:0] cv;
  logic signed [31:0] sv;

  assign cor_last = cordic_chain[uvsg_pkg::ROTATION_STAGES];
  assign cu = cor_last.u.flip ? -cor_last.u.x : cor_last.u.x;
  assign su = cor_last.u.flip ? -cor_last.u.y : cor_last.u.y;
  assign cv = cor_last.v.flip ? -cor_last.v.x : cor_last.v.x;
  assign sv = cor_last.v.flip ? -cor_last.v.y : cor_last.v.y;

  // Stage 1: cos u times cos v and sin v; sin u passes through.
  uvsg_pkg::tag_t     p1_tag;
  logic signed [63:0] p1_px;
  logic signed [63:0] p1_py;
  logic signed [31:0] p1_sz;

  // Stage 2: round products back to Q2.30.
  uvsg_pkg::tag_t     p2_tag;
  logic signed [31:0] p2_cx;
  logic signed [31:0] p2_cy;
  logic signed [31:0] p2_cz;
  logic signed [63:0] rnd_x;
  logic signed [63:0] rnd_y;

  assign rnd_x = p1_px + 64'sd536870912;
  assign rnd_y = p1_py + 64'sd536870912;

  // Stage 3: scale by radius, form normals.
  uvsg_pkg::tag_t     p3_tag;
  logic signed [48:0] p3_px;
  logic signed [48:0] p3_py;
  logic signed [48:0] p3_pz;
  logic signed [15:0] p3_nx;
  logic signed [15:0] p3_ny;
  logic signed [15:0] p3_nz;
  logic signed [16:0] radius_s;

  assign radius_s = $signed({1'b0, radius});

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_tag.valid <= 1'b0;
      p2_tag.valid <= 1'b0;
      p3_tag.valid <= 1'b0;
      out_valid    <= 1'b0;
    end else if (en) begin
      p1_tag    <= cor_last.tag;
      p2_tag    <= p1_tag;
      p3_tag    <= p2_tag;
      out_valid <= p3_tag.valid;
    end
  end

  // Payload stages hold with the pipeline; they need no reset.
  always_ff @(posedge clk) begin
    if (en) begin
      p1_px <= cu * cv;
      p1_py <= cu * sv;
      p1_sz <= su;

      p2_cx <= $signed(rnd_x[61:30]);
      p2_cy <= $signed(rnd_y[61:30]);
      p2_cz <= p1_sz;

      p3_px <= radius_s * 49'(p2_cx);
      p3_py <= radius_s * 49'(p2_cy);
      p3_pz <= radius_s * 49'(p2_cz);
      p3_nx <= uvsg_pkg::to_norm(p2_cx);
      p3_ny <= uvsg_pkg::to_norm(p2_cy);
      p3_nz <= uvsg_pkg::to_norm(p2_cz);

      // Rejected points drop to zero with the flag raised.
      if (p3_tag.oor) begin
        pos_x    <= 17'sd0;
        pos_y    <= 17'sd0;
        pos_z    <= 17'sd0;
        normal_x <= 16'sd0;
        normal_y <= 16'sd0;
        normal_z <= 16'sd0;
      end else begin
        pos_x    <= uvsg_pkg::to_pos(p3_px);
        pos_y    <= uvsg_pkg::to_pos(p3_py);
        pos_z    <= uvsg_pkg::to_pos(p3_pz);
        normal_x <= p3_nx;
        normal_y <= p3_ny;
        normal_z <= p3_nz;
      end
      out_of_range <= p3_tag.oor;
    end
  end

endmodule

`default_nettype wire
